/* sv/iterative_path_smoother_top_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the iterative path smoother.
// ---------------------------------------------------------------------------
`ifndef ITERATIVE_PATH_SMOOTHER_TOP_DEFINES_SVH
`define ITERATIVE_PATH_SMOOTHER_TOP_DEFINES_SVH
`ifndef SYNTH
`define IPS_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define IPS_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define IPS_ASSERT_IMP(label, clk, rst_n, a, c)
`define IPS_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

/* sv/ips_pkg.sv */
// ---------------------------------------------------------------------------
// ips_pkg
// Types and constants shared by the path smoother files.
// ---------------------------------------------------------------------------
`default_nettype none
package ips_pkg;
  localparam int MaxPoints = 64;
  localparam int Axes      = 3;
  localparam int Depth     = MaxPoints * Axes;
  localparam int AddrW     = $clog2(Depth);
  localparam int CntW      = $clog2(MaxPoints + 1);
  localparam int PtW       = $clog2(MaxPoints);
  localparam int ValW      = 40;
  localparam int CfgW      = 48;
  localparam logic [1:0] RegSmooth = 2'd0;
  localparam logic [1:0] RegData   = 2'd1;
  localparam logic [1:0] RegTol    = 2'd2;
  localparam logic [1:0] RegLimit  = 2'd3;

  typedef struct packed {
    logic signed [ValW-1:0] lat_in;
    logic signed [ValW-1:0] lon_in;
    logic signed [ValW-1:0] alt_in;
    logic                   final_point;
  } in_item_t;

  typedef struct packed {
    logic signed [ValW-1:0] lat_out;
    logic signed [ValW-1:0] lon_out;
    logic signed [ValW-1:0] alt_out;
    logic                   last_out;
    logic                   truncated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_WRL, ST_WRA, ST_SWEEP_START, ST_RD, ST_RD2, ST_RD3,
    ST_CALC1, ST_CALC2, ST_WB, ST_SWEEP_END, ST_EMIT_RD, ST_EMIT_RD2, ST_EMIT
  } state_t;

  function automatic logic signed [ValW-1:0] sat40(input logic signed [ValW+17:0] x);
    logic signed [ValW+17:0] mx, mn;
    mx = (ValW+18)'(signed'({1'b0, {(ValW-1){1'b1}}}));
    mn = -mx - (ValW+18)'(1);
    if (x > mx) return mx[ValW-1:0];
    if (x < mn) return mn[ValW-1:0];
    return x[ValW-1:0];
  endfunction
endpackage
`default_nettype wire

/* sv/iterative_path_smoother_top.sv */
// ---------------------------------------------------------------------------
// Iterative path smoother
// Collects a path, runs Gauss-Seidel smoothing sweeps in memory, emits it.
// ---------------------------------------------------------------------------
// Channel   Ports                               Transfer
// input     start, busy, in_item                start && !busy
// result    out_valid, out_item                 out_valid, one cycle
// config    cfg_we, cfg_index, cfg_wdata        cfg_we
// Loading writes the axes of each point to memory one per cycle, so busy
// stays high through ST_WRL and ST_WRA after each stored point. In every
// sweep each interior value goes through three memory reads, two multiply
// stages and a write back. Emission reads the axes of each point in turn.
// busy stays high from the final point until the last result. Reset is
// synchronous; the results cannot be stalled.
`default_nettype none
`include "iterative_path_smoother_top_defines.svh"
module iterative_path_smoother_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire ips_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output ips_pkg::out_item_t      out_item,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [47:0]        cfg_wdata
);
  import ips_pkg::*;

  logic signed [ValW-1:0] orig_mem [Depth];
  logic signed [ValW-1:0] sm_mem [Depth];

  logic [15:0] sw_r, dw_r, lim_r;
  logic [CfgW-1:0] tol_r;
  state_t st_r, st_nxt;
  logic [CntW-1:0] cnt_r;
  logic ovf_r, fin_r;
  logic [15:0] sweeps_r;
  logic [CfgW-1:0] sum_r;
  logic [PtW-1:0] pi_r;
  logic [1:0] ax_r;
  in_item_t hold_r;
  logic signed [ValW-1:0] rdo_r, rds_r, rdp_r, rdn_r, s1_r, new_val;
  logic signed [ValW+17:0] prod_r;

  logic [AddrW-1:0] k;
  logic [AddrW:0] kw;
  assign kw = (AddrW+1)'(pi_r) * (AddrW+1)'(Axes) + (AddrW+1)'(ax_r);
  assign k  = kw[AddrW-1:0];

  logic [AddrW:0] klw;
  logic [AddrW-1:0] wa;
  assign klw = (AddrW+1)'(cnt_r) * (AddrW+1)'(Axes);
  assign wa  = (st_r == ST_LOAD) ? klw[AddrW-1:0] : k;

  // memory address mux
  logic [AddrW-1:0] ra;
  logic             we_l;
  logic signed [ValW-1:0] wd;
  logic             wr_orig;
  always_comb begin
    ra = k;
    unique case (st_r)
      ST_RD2:  ra = k - AddrW'(Axes);
      ST_RD3:  ra = k + AddrW'(Axes);
      default: ra = k;
    endcase
  end

  logic signed [ValW-1:0] memq_r, origq_r;
  always_ff @(posedge clk) begin
    if (we_l) begin
      sm_mem[wa] <= wd;
      if (wr_orig) orig_mem[wa] <= wd;
    end
    memq_r  <= sm_mem[ra];
    origq_r <= orig_mem[ra];
  end

  logic acc;
  assign acc = start && !busy;
  assign busy = (st_r != ST_LOAD);

  logic signed [ValW+17:0] t1, nb;
  logic [ValW:0] ad;
  logic [CfgW:0] sumw;
  always_comb begin
    t1 = (ValW+18)'(signed'({1'b0, dw_r})) * ((ValW+18)'(rdo_r) - (ValW+18)'(rds_r));
    nb = (ValW+18)'(rdp_r) + (ValW+18)'(rdn_r) - ((ValW+18)'(s1_r) <<< 1);
    ad = (rds_r > new_val) ? (ValW+1)'((ValW+1)'(rds_r) - (ValW+1)'(new_val))
                           : (ValW+1)'((ValW+1)'(new_val) - (ValW+1)'(rds_r));
    sumw = (CfgW+1)'(sum_r) + (CfgW+1)'(ad);
  end

  always_comb begin
    st_nxt = st_r;
    we_l = 1'b0;
    wr_orig = 1'b0;
    wd = new_val;
    unique case (st_r)
      ST_LOAD: if (acc) begin
        if (cnt_r < CntW'(MaxPoints)) begin
          we_l = 1'b1; wr_orig = 1'b1; wd = in_item.lat_in;
          st_nxt = ST_WRL;
        end else if (in_item.final_point) st_nxt = ST_SWEEP_START;
      end
      ST_WRL: begin we_l = 1'b1; wr_orig = 1'b1; wd = hold_r.lon_in; st_nxt = ST_WRA; end
      ST_WRA: begin
        we_l = 1'b1; wr_orig = 1'b1; wd = hold_r.alt_in;
        st_nxt = fin_r ? ST_SWEEP_START : ST_LOAD;
      end
      ST_SWEEP_START:
        st_nxt = (cnt_r <= CntW'(2) || sweeps_r >= lim_r) ? ST_EMIT_RD : ST_RD;
      ST_RD:   st_nxt = ST_RD2;
      ST_RD2:  st_nxt = ST_RD3;
      ST_RD3:  st_nxt = ST_CALC1;
      ST_CALC1: st_nxt = ST_CALC2;
      ST_CALC2: st_nxt = ST_WB;
      ST_WB: begin
        we_l = 1'b1;
        if (ax_r == 2'(Axes-1) && CntW'(pi_r) + CntW'(2) >= cnt_r) st_nxt = ST_SWEEP_END;
        else st_nxt = ST_RD;
      end
      ST_SWEEP_END:
        st_nxt = (sum_r < tol_r || sweeps_r + 16'd1 >= lim_r) ? ST_EMIT_RD : ST_RD;
      ST_EMIT_RD:  st_nxt = ST_EMIT_RD2;
      ST_EMIT_RD2: st_nxt = ST_EMIT;
      ST_EMIT: begin
        if (ax_r == 2'(Axes-1)) begin
          if (CntW'(pi_r) + CntW'(1) >= cnt_r) st_nxt = ST_LOAD;
          else st_nxt = ST_EMIT_RD;
        end else st_nxt = ST_EMIT_RD;
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  logic signed [ValW-1:0] lat_r, lon_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD; cnt_r <= '0; ovf_r <= 1'b0; fin_r <= 1'b0;
      sw_r <= 16'd6554; dw_r <= 16'd32768; tol_r <= 48'd17; lim_r <= 16'd100;
      sweeps_r <= '0; sum_r <= '0; pi_r <= '0; ax_r <= '0; out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          RegSmooth: sw_r  <= cfg_wdata[15:0];
          RegData:   dw_r  <= cfg_wdata[15:0];
          RegTol:    tol_r <= cfg_wdata;
          RegLimit:  lim_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      unique case (st_r)
        ST_LOAD: begin
          if (acc) begin
            hold_r <= in_item;
            fin_r <= in_item.final_point;
            pi_r <= PtW'(cnt_r); ax_r <= 2'd1;
            if (cnt_r >= CntW'(MaxPoints)) ovf_r <= 1'b1;
            sweeps_r <= '0;
          end
        end
        ST_WRL: ax_r <= 2'd2;
        ST_WRA: begin cnt_r <= cnt_r + CntW'(1); ax_r <= '0; end
        ST_SWEEP_START: begin
          pi_r <= (st_nxt == ST_EMIT_RD) ? '0 : PtW'(1);
          ax_r <= '0; sum_r <= '0;
        end
        ST_RD2: begin rdo_r <= origq_r; rds_r <= memq_r; end
        ST_RD3: rdp_r <= memq_r;
        ST_CALC1: begin rdn_r <= memq_r; s1_r <= sat40((t1 >>> 16) + (ValW+18)'(rds_r)); end
        ST_CALC2: prod_r <= (ValW+18)'(signed'({1'b0, sw_r})) * nb;
        ST_WB: begin
          if (ax_r == 2'(Axes-1)) begin ax_r <= '0; pi_r <= pi_r + PtW'(1); end
          else ax_r <= ax_r + 2'd1;
          sum_r <= sumw[CfgW] ? {CfgW{1'b1}} : sumw[CfgW-1:0];
        end
        ST_SWEEP_END: begin
          sweeps_r <= sweeps_r + 16'd1;
          ax_r <= '0;
          if (sum_r < tol_r || sweeps_r + 16'd1 >= lim_r) pi_r <= '0;
          else begin pi_r <= PtW'(1); sum_r <= '0; end
        end
        ST_EMIT: begin
          if (ax_r == 2'd0) lat_r <= memq_r;
          if (ax_r == 2'd1) lon_r <= memq_r;
          if (ax_r == 2'(Axes-1)) begin
            out_valid <= 1'b1;
            out_item.lat_out <= lat_r;
            out_item.lon_out <= lon_r;
            out_item.alt_out <= memq_r;
            out_item.last_out <= (CntW'(pi_r) + CntW'(1) >= cnt_r);
            out_item.truncated <= ovf_r;
            ax_r <= '0; pi_r <= pi_r + PtW'(1);
            if (CntW'(pi_r) + CntW'(1) >= cnt_r) begin cnt_r <= '0; ovf_r <= 1'b0; end
          end else ax_r <= ax_r + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // The new value is formed from the registered neighbor product.
  always_comb new_val = sat40((ValW+18)'(s1_r) + (prod_r >>> 16));

  `IPS_ASSERT_IMP(a_no_accept_busy, clk, rst_n, busy, !acc)
  `IPS_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CntW'(MaxPoints))
  `IPS_ASSERT_NXT(a_emit_after, clk, rst_n, st_r == ST_EMIT && ax_r == 2'(Axes-1), out_valid)
  `IPS_ASSERT_IMP(a_valid_only_emit, clk, rst_n, out_valid, $past(st_r) == ST_EMIT)
endmodule
`default_nettype wire
